[src/pesdpk_pkg.sv]
// Package for the PES-to-ES depacketizer: parser modes, header constants and
// the result beat type. Used by every module of the block; depends on nothing.
package pesdpk_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned PosW  = 6;

  localparam logic [PosW-1:0]    FixedHeaderBytes = 6'd9;
  localparam logic [PosW-1:0]    ResetMaxHeader   = 6'd32;
  localparam logic [PosW-1:0]    PosStreamId      = 6'd3;
  localparam logic [PosW-1:0]    PosLenHigh       = 6'd4;
  localparam logic [PosW-1:0]    PosLenLow        = 6'd5;
  localparam logic [PosW-1:0]    PosHeaderLen     = 6'd8;
  localparam logic [LenW:0]      LengthFieldOffset = 17'd6;
  localparam logic [2*ByteW-1:0] HistoryCleared   = 16'hFFFF;
  localparam logic [2*ByteW-1:0] StartPrefix      = 16'h0000;
  localparam logic [ByteW-1:0]   StartLastByte    = 8'h01;

  typedef enum logic [2:0] {
    MODE_HUNT    = 3'b001,
    MODE_HEADER  = 3'b010,
    MODE_PAYLOAD = 3'b100
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] es_byte;
    logic             packet_end;
  } es_beat_t;

endpackage

[src/pesdpk_parser.sv]
// Byte parser of the PES-to-ES depacketizer: start code hunt, header walk and
// payload count, one byte per cycle while byte_fire_i is high. Depends on pesdpk_pkg.
module pesdpk_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           byte_fire_i,
  input  logic [pesdpk_pkg::ByteW-1:0]   data_byte_i,
  input  logic                           cfg_we_i,
  input  logic [pesdpk_pkg::PosW-1:0]    cfg_max_header_i,
  output logic                           res_valid_o,
  output pesdpk_pkg::es_beat_t           res_o
);

  pesdpk_pkg::mode_e                mode_q, mode_d;
  logic [2*pesdpk_pkg::ByteW-1:0]   recent_q, recent_d;
  logic [pesdpk_pkg::PosW-1:0]      header_position_q, header_position_d;
  logic [pesdpk_pkg::LenW-1:0]      packet_length_q, packet_length_d;
  logic [pesdpk_pkg::PosW-1:0]      header_skip_q, header_skip_d;
  logic [pesdpk_pkg::LenW-1:0]      payload_remaining_q, payload_remaining_d;
  logic [pesdpk_pkg::PosW-1:0]      max_header_q;

  logic [pesdpk_pkg::PosW-1:0]      pos_next;
  logic [pesdpk_pkg::PosW-1:0]      limit;
  logic [pesdpk_pkg::ByteW:0]       skip_raw;
  logic [pesdpk_pkg::PosW-1:0]      skip_clip;
  logic [pesdpk_pkg::PosW-1:0]      skip_cur;
  logic [pesdpk_pkg::LenW:0]        total;
  logic [pesdpk_pkg::LenW:0]        skip_wide;
  logic [pesdpk_pkg::LenW-1:0]      rem_dec;
  logic                             header_done;

  assign pos_next  = header_position_q + 6'd1;
  assign limit     = (max_header_q < pesdpk_pkg::FixedHeaderBytes) ?
                     pesdpk_pkg::FixedHeaderBytes : max_header_q;
  assign skip_raw  = {1'b0, data_byte_i} + {3'b000, pesdpk_pkg::FixedHeaderBytes};
  assign skip_clip = (skip_raw > {3'b000, limit}) ? limit : skip_raw[pesdpk_pkg::PosW-1:0];
  assign skip_cur  = (header_position_q == pesdpk_pkg::PosHeaderLen) ? skip_clip
                                                                     : header_skip_q;
  assign total     = {1'b0, packet_length_q} + pesdpk_pkg::LengthFieldOffset;
  assign skip_wide = {11'd0, skip_cur};
  assign rem_dec   = payload_remaining_q - 16'd1;
  assign header_done = (pos_next >= pesdpk_pkg::FixedHeaderBytes) && (pos_next >= skip_cur);

  always_comb begin
    mode_d              = mode_q;
    recent_d            = recent_q;
    header_position_d   = header_position_q;
    packet_length_d     = packet_length_q;
    header_skip_d       = header_skip_q;
    payload_remaining_d = payload_remaining_q;
    res_valid_o         = 1'b0;
    res_o.es_byte       = data_byte_i;
    res_o.packet_end    = 1'b0;
    if (byte_fire_i) begin
      unique case (mode_q)
        pesdpk_pkg::MODE_HEADER: begin
          if (header_position_q == pesdpk_pkg::PosLenHigh) begin
            packet_length_d = {data_byte_i, packet_length_q[7:0]};
          end else if (header_position_q == pesdpk_pkg::PosLenLow) begin
            packet_length_d = {packet_length_q[15:8], data_byte_i};
          end
          header_skip_d     = skip_cur;
          header_position_d = pos_next;
          if (header_done) begin
            if (total > skip_wide) begin
              payload_remaining_d = pesdpk_pkg::LenW'(total - skip_wide);
              mode_d              = pesdpk_pkg::MODE_PAYLOAD;
            end else begin
              payload_remaining_d = '0;
              mode_d              = pesdpk_pkg::MODE_HUNT;
              recent_d            = pesdpk_pkg::HistoryCleared;
            end
          end
        end
        pesdpk_pkg::MODE_PAYLOAD: begin
          payload_remaining_d = rem_dec;
          res_valid_o         = 1'b1;
          res_o.packet_end    = (rem_dec == '0);
          if (rem_dec == '0) begin
            mode_d   = pesdpk_pkg::MODE_HUNT;
            recent_d = pesdpk_pkg::HistoryCleared;
          end
        end
        default: begin
          if ((recent_q == pesdpk_pkg::StartPrefix) &&
              (data_byte_i == pesdpk_pkg::StartLastByte)) begin
            mode_d            = pesdpk_pkg::MODE_HEADER;
            header_position_d = pesdpk_pkg::PosStreamId;
            packet_length_d   = '0;
            header_skip_d     = '0;
            recent_d          = pesdpk_pkg::HistoryCleared;
          end else begin
            mode_d   = pesdpk_pkg::MODE_HUNT;
            recent_d = {recent_q[pesdpk_pkg::ByteW-1:0], data_byte_i};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q              <= pesdpk_pkg::MODE_HUNT;
      recent_q            <= pesdpk_pkg::HistoryCleared;
      header_position_q   <= '0;
      packet_length_q     <= '0;
      header_skip_q       <= '0;
      payload_remaining_q <= '0;
      max_header_q        <= pesdpk_pkg::ResetMaxHeader;
    end else begin
      mode_q              <= mode_d;
      recent_q            <= recent_d;
      header_position_q   <= header_position_d;
      packet_length_q     <= packet_length_d;
      header_skip_q       <= header_skip_d;
      payload_remaining_q <= payload_remaining_d;
      if (cfg_we_i) begin
        max_header_q <= cfg_max_header_i;
      end
    end
  end

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == pesdpk_pkg::MODE_PAYLOAD |-> payload_remaining_q != '0)
    else $error("payload mode entered with no bytes left");

  a_payload_skip_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == pesdpk_pkg::MODE_PAYLOAD |-> header_skip_q >= pesdpk_pkg::FixedHeaderBytes)
    else $error("payload mode reached before the header length was latched");

  a_header_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == pesdpk_pkg::MODE_HEADER |-> header_position_q >= pesdpk_pkg::PosStreamId)
    else $error("header position below the stream id byte");

endmodule

[src/pesdpk_skid.sv]
// Two-entry output buffer of the PES-to-ES depacketizer: an output register
// and a skid register, so the input side keeps moving while a beat waits.
// Depends on pesdpk_pkg.
module pesdpk_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pesdpk_pkg::es_beat_t beat_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pesdpk_pkg::es_beat_t out_beat_o
);

  logic                 out_valid_q;
  logic                 skid_valid_q;
  pesdpk_pkg::es_beat_t out_beat_q;
  pesdpk_pkg::es_beat_t skid_beat_q;
  logic                 out_fire;

  assign out_fire    = out_valid_q & out_ready_i;
  assign room_o      = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_beat_q <= skid_beat_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_ready_i) begin
        skid_beat_q <= beat_i;
      end else begin
        out_beat_q <= beat_i;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && out_valid_q && !out_ready_i |=> skid_valid_q)
    else $error("beat pushed during a stall was not kept in the skid register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("beat pushed while both buffer entries are full");

endmodule

[src/pes_to_es_depacketizer_top.sv]
// Top level of the PES-to-ES depacketizer: byte parser plus output buffer.
// Depends on pesdpk_pkg, pesdpk_parser and pesdpk_skid.
//
// The input channel (data_valid_i, data_ready_o, data_byte_i) carries the raw
// PES stream, one byte per beat. The output channel (es_valid_o, es_ready_i,
// es_byte_o, packet_end_o) carries only elementary-stream payload bytes, with
// packet_end_o set on the last payload byte of each packet. Start codes,
// header bytes and bytes seen while hunting produce no output beat.
// Every input byte is handled in the cycle it is accepted, and its output
// beat, if any, is registered in the output or the skid register. One byte
// per cycle is sustained while the receiver keeps es_ready_i high. The output
// side is an output register plus a skid register. When the receiver stalls,
// bytes that make no beat keep flowing, one more payload beat is parked in the
// skid register, and then data_ready_o drops until the output register drains.
// Reset puts the parser in start-code hunt, clears the output buffer and sets
// max_header_bytes to 32. max_header_bytes_i is written on any cycle with
// max_header_bytes_we_i high and takes effect once registered, even mid-header.
module pes_to_es_depacketizer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         data_valid_i,
  output logic                         data_ready_o,
  input  logic [pesdpk_pkg::ByteW-1:0] data_byte_i,
  input  logic                         max_header_bytes_we_i,
  input  logic [pesdpk_pkg::PosW-1:0]  max_header_bytes_i,
  output logic                         es_valid_o,
  input  logic                         es_ready_i,
  output logic [pesdpk_pkg::ByteW-1:0] es_byte_o,
  output logic                         packet_end_o
);

  logic                 byte_fire;
  logic                 res_valid;
  logic                 room;
  pesdpk_pkg::es_beat_t res_beat;
  pesdpk_pkg::es_beat_t out_beat;

  assign data_ready_o = room;
  assign byte_fire    = data_valid_i & room;

  pesdpk_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .byte_fire_i      (byte_fire),
    .data_byte_i      (data_byte_i),
    .cfg_we_i         (max_header_bytes_we_i),
    .cfg_max_header_i (max_header_bytes_i),
    .res_valid_o      (res_valid),
    .res_o            (res_beat)
  );

  pesdpk_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .beat_i      (res_beat),
    .room_o      (room),
    .out_valid_o (es_valid_o),
    .out_ready_i (es_ready_i),
    .out_beat_o  (out_beat)
  );

  assign es_byte_o    = out_beat.es_byte;
  assign packet_end_o = out_beat.packet_end;

endmodule
